/* hw/rtl/skt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skt_pkg: shared types and constants for the sorted key table
// Command codes, default sizes and the per-cell compare flags.
// ----------------------------------------------------------------------------
package skt_pkg;

	// Default capacity and key width
	localparam int ENTRIES_DEF  = 64;
	localparam int KEY_BITS_DEF = 8;

	// Fixed field widths of the command and result ports
	localparam int CMD_W   = 2;
	localparam int KEY_W   = 8;
	localparam int POS_W   = 6;
	localparam int COUNT_W = 7;

	// Command codes
	typedef enum logic [CMD_W-1:0] {
		CMD_LOOKUP = 2'd0,
		CMD_INSERT = 2'd1,
		CMD_NEXT   = 2'd2
	} cmd_t;

	// Compare flags one cell reports for the probed key
	typedef struct packed {
		logic lt;   // valid and stored key below probe
		logic eq;   // valid and stored key equals probe
		logic gt;   // valid and stored key above probe
	} cell_flags_t;

endpackage

/* hw/rtl/skt_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skt_cell: one slot of the sorted key row
// Holds one key, compares it to the probe key and shifts in its lower
// neighbor's key (or the new key) when an insert lands at or below it.
// ----------------------------------------------------------------------------
module skt_cell import skt_pkg::*; #(
	parameter int KEY_BITS = KEY_BITS_DEF,
	parameter int CNT_W    = 7,
	parameter int INDEX    = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                probe_en,
	input  logic [KEY_BITS-1:0] probe_key,
	input  logic [CNT_W-1:0]    count,
	input  logic                shift_en,
	input  logic                prev_lt,
	input  logic [KEY_BITS-1:0] prev_key,
	input  logic [KEY_BITS-1:0] new_key,
	output logic [KEY_BITS-1:0] key_q,
	output cell_flags_t         flags_s1
);

	logic        valid;
	cell_flags_t flags;

	// Slot holds a key when it lies below the fill count
	assign valid = CNT_W'(INDEX) < count;

	always_comb begin
		flags.lt = valid && (key_q < probe_key);
		flags.eq = valid && (key_q == probe_key);
		flags.gt = valid && (key_q > probe_key);
	end

	// Compare flags, captured on the command transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_s1 <= '0;
		end else if (probe_en) begin
			flags_s1 <= flags;
		end
	end

	// Insert: the slot at the insert point takes the new key, slots above
	// take their neighbor's key
	always_ff @(posedge clk) begin
		if (shift_en && !flags_s1.lt) begin
			key_q <= prev_lt ? new_key : prev_key;
		end
	end

endmodule

/* hw/rtl/sorted_key_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_key_table: ascending table of unique keys
// Lookup, insert-if-absent and next-larger-key over a row of compare cells.
// ----------------------------------------------------------------------------
// Usage:
//   A command transfers at a rising edge with start high and busy low.
//   The row of cells compares the key against every stored key at that
//   edge; busy is then high for one cycle while the flags are resolved and
//   an insert shifts the upper cells by one slot. The result appears on the
//   result ports for exactly one cycle with done high, registered as the
//   busy state ends, and the next command can transfer in that same cycle.
//   Each command thus passes the registered compare stage and then the
//   resolve/shift state of the cell row.
//   Keys are compared on their low KEY_BITS bits. Inserting an absent key
//   into a full table (ENTRIES keys) is refused and flagged with table_full.
//   Reset clears the fill count and the control state; stored key slots
//   are only read below the fill count and need no clearing.
//   The receiver cannot stall: each result is taken in the cycle it shows.
// ----------------------------------------------------------------------------
module sorted_key_table import skt_pkg::*; #(
	parameter int ENTRIES  = ENTRIES_DEF,
	parameter int KEY_BITS = KEY_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [CMD_W-1:0]   command,
	input  logic [KEY_W-1:0]   key,
	output logic               done,
	output logic               hit,
	output logic [POS_W-1:0]   position,
	output logic [KEY_W-1:0]   follower_key,
	output logic               follower_valid,
	output logic               table_full,
	output logic [COUNT_W-1:0] entry_count
);

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W = $clog2(ENTRIES + 1);

	typedef enum logic {
		S_IDLE,
		S_RESOLVE
	} state_t;

	state_t              state_q;
	logic [CMD_W-1:0]    cmd_q;
	logic [KEY_BITS-1:0] key_q;
	logic [CNT_W-1:0]    count_q;

	logic                accept;
	logic [KEY_BITS-1:0] probe_key;
	logic                shift_en;
	logic                is_full;

	logic [KEY_BITS-1:0] cell_key   [ENTRIES];
	cell_flags_t         cell_flags [ENTRIES];

	logic                present;
	logic [IDX_W-1:0]    hit_idx;
	logic [IDX_W-1:0]    ins_idx;
	logic                fol_valid;
	logic [KEY_BITS-1:0] fol_key;

	assign accept    = start && !busy;
	assign busy      = (state_q == S_RESOLVE);
	assign probe_key = KEY_BITS'(key);
	assign is_full   = (count_q == CNT_W'(ENTRIES));
	assign shift_en  = busy && (cmd_q == CMD_INSERT) && !present && !is_full;

	// Row of cells, each fed by its lower neighbor
	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		logic                prev_lt;
		logic [KEY_BITS-1:0] prev_key;

		if (i == 0) begin : g_first
			assign prev_lt  = 1'b1;
			assign prev_key = key_q;
		end else begin : g_next
			assign prev_lt  = cell_flags[i-1].lt;
			assign prev_key = cell_key[i-1];
		end

		skt_cell #(
			.KEY_BITS (KEY_BITS),
			.CNT_W    (CNT_W),
			.INDEX    (i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.probe_en  (accept),
			.probe_key (probe_key),
			.count     (count_q),
			.shift_en  (shift_en),
			.prev_lt   (prev_lt),
			.prev_key  (prev_key),
			.new_key   (key_q),
			.key_q     (cell_key[i]),
			.flags_s1  (cell_flags[i])
		);
	end

	// Resolve the one-hot edges of the flag row: match, insert point,
	// first larger key
	always_comb begin
		logic lt_below;
		logic gt_below;
		present   = 1'b0;
		hit_idx   = '0;
		ins_idx   = '0;
		fol_valid = 1'b0;
		fol_key   = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			lt_below = (i == 0) ? 1'b1 : cell_flags[(i == 0) ? 0 : i-1].lt;
			gt_below = (i == 0) ? 1'b0 : cell_flags[(i == 0) ? 0 : i-1].gt;
			if (cell_flags[i].eq) begin
				present = 1'b1;
				hit_idx = hit_idx | IDX_W'(i);
			end
			if (lt_below && !cell_flags[i].lt) begin
				ins_idx = ins_idx | IDX_W'(i);
			end
			if (cell_flags[i].gt) begin
				fol_valid = 1'b1;
			end
			if (cell_flags[i].gt && !gt_below) begin
				fol_key = fol_key | cell_key[i];
			end
		end
	end

	// Control, fill count and registered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			cmd_q          <= '0;
			key_q          <= '0;
			count_q        <= '0;
			done           <= 1'b0;
			hit            <= 1'b0;
			position       <= '0;
			follower_key   <= '0;
			follower_valid <= 1'b0;
			table_full     <= 1'b0;
			entry_count    <= '0;
		end else begin
			done <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						cmd_q   <= command;
						key_q   <= probe_key;
						state_q <= S_RESOLVE;
					end
				end
				S_RESOLVE: begin
					state_q        <= S_IDLE;
					done           <= 1'b1;
					hit            <= 1'b0;
					position       <= '0;
					follower_key   <= '0;
					follower_valid <= 1'b0;
					table_full     <= 1'b0;
					entry_count    <= COUNT_W'(count_q);
					case (cmd_q)
						CMD_LOOKUP: begin
							hit      <= present;
							position <= present ? POS_W'(hit_idx) : '0;
						end
						CMD_INSERT: begin
							if (present) begin
								hit      <= 1'b1;
								position <= POS_W'(hit_idx);
							end else if (is_full) begin
								table_full <= 1'b1;
							end else begin
								position    <= POS_W'(ins_idx);
								count_q     <= count_q + 1'b1;
								entry_count <= COUNT_W'(count_q + 1'b1);
							end
						end
						CMD_NEXT: begin
							hit            <= present;
							position       <= present ? POS_W'(hit_idx) : '0;
							follower_valid <= fol_valid;
							follower_key   <= KEY_W'(fol_key);
						end
						default: begin
						end
					endcase
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

/* hw/rtl/skt_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skt_checker: port-level checks for the sorted key table
// Watches the command and result ports and is bound to the top level.
// ----------------------------------------------------------------------------
module skt_checker import skt_pkg::*; #(
	parameter int ENTRIES = ENTRIES_DEF
) (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input logic               hit,
	input logic               table_full,
	input logic [COUNT_W-1:0] entry_count
);

	// A command transfer always leads to one busy cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("command transfer not followed by busy");

	// Busy lasts one cycle and ends in a result
	a_busy_done: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> done && !busy)
		else $error("busy cycle not followed by result");

	// A result only follows a busy cycle
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without a command in work");

	// A refused insert only happens on a full table and is never a hit
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		done && table_full |-> !hit && (entry_count == COUNT_W'(ENTRIES)))
		else $error("table_full with room left or with a hit");

endmodule

bind sorted_key_table skt_checker #(
	.ENTRIES (ENTRIES)
) u_skt_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.done        (done),
	.hit         (hit),
	.table_full  (table_full),
	.entry_count (entry_count)
);

/* verif/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for sorted_key_table
// Drives lookup, insert, next and the unused command code through the
// start/busy handshake with random gaps. Every transfer is run through a
// software copy of the sorted table, and each done strobe is checked field
// by field against the oldest expected result.
// ----------------------------------------------------------------------------
module tb;
	import skt_pkg::*;

	localparam int ENTRIES      = ENTRIES_DEF;
	localparam int KEY_BITS     = KEY_BITS_DEF;
	localparam int RANDOM_ITEMS = 1000;
	localparam int CYCLE_LIMIT  = 200000;

	// Command code the block ignores (still answers with the fill count)
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	typedef struct packed {
		logic               hit;
		logic [POS_W-1:0]   position;
		logic [KEY_W-1:0]   follower_key;
		logic               follower_valid;
		logic               table_full;
		logic [COUNT_W-1:0] entry_count;
	} table_result_t;

	// Sorted key table model plus the queue of results still to come
	class key_table_scoreboard;
		logic [KEY_BITS-1:0] keys [ENTRIES];
		int                  count;
		int                  errors;
		table_result_t       awaited_q [$];

		function new();
			count  = 0;
			errors = 0;
		endfunction

		task report_mismatch(string msg);
			$display("ERROR @%0t: %s", $time, msg);
			errors++;
		endtask

		// Apply one transferred command to the table copy, queue its result
		function void note_command(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key_in);
			logic [KEY_BITS-1:0] k;
			int                  lb;
			int                  f;
			bit                  present;
			table_result_t       r;
			k  = key_in[KEY_BITS-1:0];
			lb = 0;
			while (lb < count && keys[lb] < k)
				lb++;
			present = (lb < count) && (keys[lb] == k);
			r = '0;
			case (cmd)
				CMD_LOOKUP: begin
					if (present) begin
						r.hit      = 1'b1;
						r.position = lb[POS_W-1:0];
					end
				end
				CMD_INSERT: begin
					if (present) begin
						r.hit      = 1'b1;
						r.position = lb[POS_W-1:0];
					end else if (count >= ENTRIES) begin
						r.table_full = 1'b1;
					end else begin
						// shift larger keys up one slot
						for (int i = count; i > lb; i--)
							keys[i] = keys[i-1];
						keys[lb] = k;
						count++;
						r.position = lb[POS_W-1:0];
					end
				end
				CMD_NEXT: begin
					if (present) begin
						r.hit      = 1'b1;
						r.position = lb[POS_W-1:0];
					end
					f = present ? lb + 1 : lb;
					if (f < count) begin
						r.follower_key   = KEY_W'(keys[f]);
						r.follower_valid = 1'b1;
					end
				end
				default: ;
			endcase
			r.entry_count = count[COUNT_W-1:0];
			awaited_q.push_back(r);
		endfunction

		// Compare one strobed result with the oldest expectation
		task check_result(table_result_t got);
			table_result_t want;
			if (awaited_q.size() == 0) begin
				report_mismatch("result strobed with nothing expected");
				return;
			end
			want = awaited_q.pop_front();
			if (got.hit !== want.hit)
				report_mismatch($sformatf("hit got %b want %b", got.hit, want.hit));
			if (got.position !== want.position)
				report_mismatch($sformatf("position got %0d want %0d",
					got.position, want.position));
			if (got.follower_key !== want.follower_key)
				report_mismatch($sformatf("follower_key got %0d want %0d",
					got.follower_key, want.follower_key));
			if (got.follower_valid !== want.follower_valid)
				report_mismatch($sformatf("follower_valid got %b want %b",
					got.follower_valid, want.follower_valid));
			if (got.table_full !== want.table_full)
				report_mismatch($sformatf("table_full got %b want %b",
					got.table_full, want.table_full));
			if (got.entry_count !== want.entry_count)
				report_mismatch($sformatf("entry_count got %0d want %0d",
					got.entry_count, want.entry_count));
		endtask
	endclass

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [CMD_W-1:0]   command;
	logic [KEY_W-1:0]   key;
	logic               done;
	logic               hit;
	logic [POS_W-1:0]   position;
	logic [KEY_W-1:0]   follower_key;
	logic               follower_valid;
	logic               table_full;
	logic [COUNT_W-1:0] entry_count;

	key_table_scoreboard sb;
	int                  items_sent;
	int                  cycles;

	sorted_key_table #(
		.ENTRIES  (ENTRIES),
		.KEY_BITS (KEY_BITS)
	) uut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Run limit
	initial cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("sorted_key_table test failed");
			$finish;
		end
	end

	// Result monitor: the receiver never stalls, every done is a transfer
	always @(posedge clk) begin
		table_result_t got;
		if (done === 1'b1) begin
			got = '{hit, position, follower_key, follower_valid, table_full, entry_count};
			sb.check_result(got);
		end
	end

	// Hold the command until it transfers, then note it
	task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] k);
		start   <= 1'b1;
		command <= cmd;
		key     <= k;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		sb.note_command(cmd, k);
	endtask

	// Idle cycles with junk on the command fields
	task automatic idle_for(input int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) begin
				command <= CMD_W'($urandom);
				key     <= KEY_W'($urandom);
				@(posedge clk);
			end
		end
	endtask

	// Mostly short gaps, a few long ones, and regular back-to-back bursts
	function automatic int pick_gap(input int n);
		int r;
		if ((n % 200) < 40)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	function automatic logic [CMD_W-1:0] pick_command(input int insert_pct);
		int r;
		r = $urandom_range(0, 99);
		if (r < insert_pct)
			return CMD_INSERT;
		if (r < insert_pct + 5)
			return CMD_UNUSED;
		return (r % 2) ? CMD_LOOKUP : CMD_NEXT;
	endfunction

	// Favor stored keys and their neighbors so hits and followers show up
	function automatic logic [KEY_W-1:0] pick_key();
		int r;
		int idx;
		r = $urandom_range(0, 9);
		if (sb.count > 0 && r < 6) begin
			idx = $urandom_range(0, sb.count - 1);
			if (r < 4)
				return KEY_W'(sb.keys[idx]);
			if (r == 4)
				return KEY_W'(sb.keys[idx]) + 1'b1;
			return KEY_W'(sb.keys[idx]) - 1'b1;
		end
		if (r == 6)
			return ($urandom_range(0, 1) != 0) ? '1 : '0;
		return KEY_W'($urandom);
	endfunction

	task automatic issue(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] k);
		send_command(cmd, k);
		idle_for(pick_gap(items_sent));
		items_sent++;
	endtask

	initial begin
		sb         = new();
		items_sent = 0;
		arst_n  <= 1'b0;
		start   <= 1'b0;
		command <= CMD_LOOKUP;
		key     <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty table: misses, no follower, ignored code
		issue(CMD_LOOKUP, 8'd0);
		issue(CMD_NEXT, 8'd0);
		issue(CMD_UNUSED, 8'd255);
		// First inserts, including both key extremes and a duplicate
		issue(CMD_INSERT, 8'd128);
		issue(CMD_INSERT, 8'd0);
		issue(CMD_INSERT, 8'd255);
		issue(CMD_INSERT, 8'd128);
		issue(CMD_LOOKUP, 8'd255);
		issue(CMD_LOOKUP, 8'd7);
		// Next on present, absent and largest keys
		issue(CMD_NEXT, 8'd0);
		issue(CMD_NEXT, 8'd127);
		issue(CMD_NEXT, 8'd255);
		issue(CMD_NEXT, 8'd200);
		issue(CMD_UNUSED, 8'd0);
		issue(CMD_INSERT, 8'd1);
		issue(CMD_INSERT, 8'd254);
		issue(CMD_INSERT, 8'h55);
		issue(CMD_INSERT, 8'hAA);
		issue(CMD_LOOKUP, 8'd1);
		issue(CMD_NEXT, 8'd254);
		issue(CMD_NEXT, 8'h54);
		issue(CMD_LOOKUP, 8'hAA);

		// Random part: slow fill first, then fill up and hit the full table
		for (int i = 0; i < RANDOM_ITEMS; i++)
			issue(pick_command((i < 600) ? 8 : 30), pick_key());
		start <= 1'b0;

		// Drain outstanding results, then watch for strays
		while (sb.awaited_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.awaited_q.size() != 0)
			sb.report_mismatch("expected results left over");

		if (sb.errors == 0)
			$display("sorted_key_table test passed");
		else
			$display("sorted_key_table test failed");
		$finish;
	end

endmodule
